[rtl/ppt_pkg.sv]
`timescale 1ns / 1ps

package ppt_pkg;

  localparam logic [14:0] PI2_Q12 = 15'd25736;
  localparam logic [14:0] LOCK_Q12 = 15'd205;
  localparam logic signed [37:0] INTEG_MAX = 38'sd3276800;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_SPEED_LIMIT   = 3'd2,
    REG_SMOOTH_WEIGHT = 3'd3,
    REG_SMOOTH_ENABLE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] prop_gain;
    logic [31:0] integral_gain;
    logic [30:0] speed_limit;
    logic [16:0] smoothing_weight;
    logic        smoothing_enable;
  } cfg_t;

  typedef struct packed {
    logic                      en;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PREP,
    S_M_KI,
    S_M_HI,
    S_M_LO,
    S_INC,
    S_INTEG,
    S_OMEGA,
    S_M_OD,
    S_THETA,
    S_M_BT1,
    S_M_BT2,
    S_BT,
    S_M_BO2,
    S_BO,
    S_DONE
  } state_t;

endpackage

[rtl/pll_pi_phase_tracker_unit.sv]
`timescale 1ns / 1ps
// a new beat is accepted only in the idle state, after the previous beat is done;
// the pace of the computation is set by the one
// shared 33x25 multiplier that serves five products (nine with smoothing)
// a waiting result is held in the output register while the next beat computes
// reset (rst, synchronous): registers to defaults, loop state cleared to zero

module pll_pi_phase_tracker_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [15:0]                 phase_err,
  input  logic [23:0]                        time_step,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [31:0]                 angle_est,
  output logic signed [31:0]                 speed_est,
  output logic                               locked,
  output logic [14:0]                        peak_error
);

  ppt_pkg::cfg_t cfg;
  ppt_pkg::mul_req_t mul_req;
  logic signed [ppt_pkg::MUL_P_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= 32'd65536;
      cfg.integral_gain    <= 32'd0;
      cfg.speed_limit      <= 31'd655360000;
      cfg.smoothing_weight <= 17'd0;
      cfg.smoothing_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (ppt_pkg::reg_idx_t'(cfg_index))
        ppt_pkg::REG_PROP_GAIN:     cfg.prop_gain        <= cfg_data;
        ppt_pkg::REG_INTEGRAL_GAIN: cfg.integral_gain    <= cfg_data;
        ppt_pkg::REG_SPEED_LIMIT:   cfg.speed_limit      <= cfg_data[30:0];
        ppt_pkg::REG_SMOOTH_WEIGHT: cfg.smoothing_weight <= cfg_data[16:0];
        ppt_pkg::REG_SMOOTH_ENABLE: cfg.smoothing_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ppt_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .phase_err  (phase_err),
    .time_step  (time_step),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .angle_est  (angle_est),
    .speed_est  (speed_est),
    .locked     (locked),
    .peak_error (peak_error),
    .mul_req    (mul_req),
    .prod       (prod)
  );

  ppt_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

endmodule

[rtl/ppt_mul.sv]
`timescale 1ns / 1ps

module ppt_mul (
  input  logic                                  clk,
  input  ppt_pkg::mul_req_t                     req,
  output logic signed [ppt_pkg::MUL_P_W-1:0]    prod
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * req.b;
    end
  end

endmodule

[rtl/ppt_core.sv]
`timescale 1ns / 1ps

module ppt_core (
  input  logic                                clk,
  input  logic                                rst,
  input  ppt_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [15:0]                  phase_err,
  input  logic [23:0]                         time_step,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  angle_est,
  output logic signed [31:0]                  speed_est,
  output logic                                locked,
  output logic [14:0]                         peak_error,
  output ppt_pkg::mul_req_t                   mul_req,
  input  logic signed [ppt_pkg::MUL_P_W-1:0]  prod
);

  localparam int PW = ppt_pkg::MUL_P_W;

  ppt_pkg::state_t state, state_next;

  logic signed [15:0] err_q;
  logic [23:0]        dt_q;
  logic [14:0]        mag;
  logic               neg;
  logic               locked_q;
  logic [14:0]        peak_reg;
  logic [23:0]        lo_q;
  logic signed [PW-1:0] acc;
  logic [35:0]        inc_mag;
  logic signed [31:0] integ_reg, integ_new;
  logic signed [31:0] omega_new, theta_new;
  logic signed [31:0] angle_reg, speed_reg;

  logic [16:0]        alpha, alpha_c;
  logic signed [15:0] err_c;
  logic               load_out;
  logic [47:0]        inc_sum;
  logic signed [37:0] inc_s, integ_sum;
  logic signed [37:0] kp_s, omega_sum, omega_lim;
  logic signed [PW-1:0] delta, blend_sum, blend_q;

  function automatic logic signed [PW-1:0] shr_tz(input logic signed [PW-1:0] v,
                                                  input int unsigned sh);
    logic [PW-1:0] m;
    logic [PW-1:0] s;
    m = v[PW-1] ? PW'(-v) : PW'(v);
    s = m >> sh;
    return v[PW-1] ? -$signed(s) : $signed(s);
  endfunction

  function automatic logic mag_next_gt_peak(input logic signed [15:0] e,
                                            input logic [14:0] pk);
    logic [14:0] m;
    m = e[15] ? 15'(-e) : e[14:0];
    return m > pk;
  endfunction

  assign alpha = (cfg.smoothing_weight > ppt_pkg::ALPHA_ONE) ? ppt_pkg::ALPHA_ONE
                                                           : cfg.smoothing_weight;
  assign alpha_c = ppt_pkg::ALPHA_ONE - alpha;

  // error clamp to +-2pi
  always_comb begin
    if (err_q > $signed({1'b0, ppt_pkg::PI2_Q12})) begin
      err_c = $signed({1'b0, ppt_pkg::PI2_Q12});
    end else if (err_q < -$signed({1'b0, ppt_pkg::PI2_Q12})) begin
      err_c = -$signed({1'b0, ppt_pkg::PI2_Q12});
    end else begin
      err_c = err_q;
    end
  end

  // integrator update
  assign inc_sum = {1'b0, acc[46:0]} + {24'd0, prod[47:24]};
  assign inc_s = neg ? -$signed({2'b00, inc_mag}) : $signed({2'b00, inc_mag});
  assign integ_sum = {{6{integ_reg[31]}}, integ_reg} + inc_s;

  // omega
  assign kp_s = neg ? -$signed({3'b000, prod[46:12]}) : $signed({3'b000, prod[46:12]});
  assign omega_sum = kp_s + {{6{integ_new[31]}}, integ_new};
  assign omega_lim = $signed({7'd0, cfg.speed_limit});

  assign delta = shr_tz(prod, 24);
  assign blend_sum = acc + prod;
  assign blend_q = shr_tz(blend_sum, 16);

  assign in_ready = (state == ppt_pkg::S_IDLE);
  assign load_out = (state == ppt_pkg::S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_req = '0;
    unique case (state)
      ppt_pkg::S_IDLE: begin
        if (in_valid) state_next = ppt_pkg::S_PREP;
      end
      ppt_pkg::S_PREP: state_next = ppt_pkg::S_M_KI;
      ppt_pkg::S_M_KI: begin
        mul_req.en = 1'b1;
        mul_req.a = {1'b0, cfg.integral_gain};
        mul_req.b = {10'd0, mag};
        state_next = ppt_pkg::S_M_HI;
      end
      ppt_pkg::S_M_HI: begin
        mul_req.en = 1'b1;
        mul_req.a = {10'd0, prod[46:24]};
        mul_req.b = {1'b0, dt_q};
        state_next = ppt_pkg::S_M_LO;
      end
      ppt_pkg::S_M_LO: begin
        mul_req.en = 1'b1;
        mul_req.a = {9'd0, lo_q};
        mul_req.b = {1'b0, dt_q};
        state_next = ppt_pkg::S_INC;
      end
      ppt_pkg::S_INC: begin
        mul_req.en = 1'b1;
        mul_req.a = {1'b0, cfg.prop_gain};
        mul_req.b = {10'd0, mag};
        state_next = ppt_pkg::S_INTEG;
      end
      ppt_pkg::S_INTEG: state_next = ppt_pkg::S_OMEGA;
      ppt_pkg::S_OMEGA: state_next = ppt_pkg::S_M_OD;
      ppt_pkg::S_M_OD: begin
        mul_req.en = 1'b1;
        mul_req.a = {omega_new[31], omega_new};
        mul_req.b = {1'b0, dt_q};
        state_next = ppt_pkg::S_THETA;
      end
      ppt_pkg::S_THETA: begin
        state_next = cfg.smoothing_enable ? ppt_pkg::S_M_BT1 : ppt_pkg::S_DONE;
      end
      ppt_pkg::S_M_BT1: begin
        mul_req.en = 1'b1;
        mul_req.a = {angle_reg[31], angle_reg};
        mul_req.b = {8'd0, alpha};
        state_next = ppt_pkg::S_M_BT2;
      end
      ppt_pkg::S_M_BT2: begin
        mul_req.en = 1'b1;
        mul_req.a = {theta_new[31], theta_new};
        mul_req.b = {8'd0, alpha_c};
        state_next = ppt_pkg::S_BT;
      end
      ppt_pkg::S_BT: begin
        mul_req.en = 1'b1;
        mul_req.a = {speed_reg[31], speed_reg};
        mul_req.b = {8'd0, alpha};
        state_next = ppt_pkg::S_M_BO2;
      end
      ppt_pkg::S_M_BO2: begin
        mul_req.en = 1'b1;
        mul_req.a = {omega_new[31], omega_new};
        mul_req.b = {8'd0, alpha_c};
        state_next = ppt_pkg::S_BO;
      end
      ppt_pkg::S_BO: state_next = ppt_pkg::S_DONE;
      ppt_pkg::S_DONE: begin
        if (!out_valid || out_ready) state_next = ppt_pkg::S_IDLE;
      end
      default: state_next = ppt_pkg::S_IDLE;
    endcase
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_reg <= '0;
      speed_reg <= '0;
      integ_reg <= '0;
      peak_reg  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ppt_pkg::S_PREP && mag_next_gt_peak(err_c, peak_reg)) begin
        peak_reg <= err_c[15] ? 15'(-err_c) : err_c[14:0];
      end
      if (load_out) begin
        angle_reg <= theta_new;
        speed_reg <= omega_new;
        integ_reg <= integ_new;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ppt_pkg::S_IDLE && in_valid) begin
      err_q <= phase_err;
      dt_q  <= time_step;
    end
    case (state)
      ppt_pkg::S_PREP: begin
        neg      <= err_c[15];
        mag      <= err_c[15] ? 15'(-err_c) : err_c[14:0];
        locked_q <= (err_c[15] ? 15'(-err_c) : err_c[14:0]) < ppt_pkg::LOCK_Q12;
      end
      ppt_pkg::S_M_HI: lo_q <= prod[23:0];
      ppt_pkg::S_M_LO: acc <= prod;
      ppt_pkg::S_INC: inc_mag <= inc_sum[47:12];
      ppt_pkg::S_INTEG: begin
        if (integ_sum > ppt_pkg::INTEG_MAX) begin
          integ_new <= 32'(ppt_pkg::INTEG_MAX);
        end else if (integ_sum < -ppt_pkg::INTEG_MAX) begin
          integ_new <= 32'(-ppt_pkg::INTEG_MAX);
        end else begin
          integ_new <= integ_sum[31:0];
        end
      end
      ppt_pkg::S_OMEGA: begin
        if (omega_sum > omega_lim) begin
          omega_new <= omega_lim[31:0];
        end else if (omega_sum < -omega_lim) begin
          omega_new <= 32'(-omega_lim);
        end else begin
          omega_new <= omega_sum[31:0];
        end
      end
      ppt_pkg::S_THETA: theta_new <= angle_reg + delta[31:0];
      ppt_pkg::S_M_BT2: acc <= prod;
      ppt_pkg::S_BT: theta_new <= blend_q[31:0];
      ppt_pkg::S_M_BO2: acc <= prod;
      ppt_pkg::S_BO: omega_new <= blend_q[31:0];
      default: ;
    endcase
    if (load_out) begin
      angle_est  <= theta_new;
      speed_est  <= omega_new;
      locked     <= locked_q;
      peak_error <= peak_reg;
    end
  end

endmodule

[rtl/ppt_checker.sv]
`timescale 1ns / 1ps

module ppt_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [31:0]  angle_est,
  input logic signed [31:0]  speed_est,
  input logic [14:0]         peak_error
);

  // reset leaves the block ready with nothing pending
  assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

  // an accepted beat keeps the input side closed while it computes
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken during computation");

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(angle_est) && $stable(speed_est))
    else $error("result changed while stalled");

  // peak magnitude never exceeds the clamp
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> peak_error <= ppt_pkg::PI2_Q12)
    else $error("peak error above clamp");

endmodule

bind pll_pi_phase_tracker_unit ppt_checker u_ppt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .angle_est  (angle_est),
  .speed_est  (speed_est),
  .peak_error (peak_error)
);
